@@ design/cds_pkg.sv @@
// cds_pkg: shared types and constants of the COTP data segmenter.
// No dependencies; compiled first.
package cds_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned MSG_LEN_W  = 17;  // message length / bytes left in message
  localparam int unsigned TPDU_W     = 14;  // tpdu_size register
  localparam int unsigned FRAG_W     = 13;  // fragment capacity / bytes left in fragment
  localparam int unsigned TPKT_LEN_W = 14;  // 7 + fragment payload, at most 8196

  localparam logic [MSG_LEN_W-1:0] MAX_MESSAGE_BYTES = 17'd65536;
  localparam logic [TPDU_W-1:0]    TPDU_MIN          = 14'd128;
  localparam logic [TPDU_W-1:0]    TPDU_MAX          = 14'd8192;
  localparam logic [TPDU_W-1:0]    TPDU_RESET        = 14'd8192;
  localparam logic [TPDU_W-1:0]    DATA_HEADER_BYTES = 14'd3;
  localparam logic [TPKT_LEN_W-1:0] FRAME_HEADER_BYTES = 14'd7;

  // header byte values
  localparam logic [BYTE_W-1:0] TPKT_VERSION  = 8'h03;
  localparam logic [BYTE_W-1:0] TPKT_RESERVED = 8'h00;
  localparam logic [BYTE_W-1:0] DT_LI         = 8'h02;
  localparam logic [BYTE_W-1:0] DT_CODE       = 8'hF0;
  localparam logic [BYTE_W-1:0] DT_EOT_LAST   = 8'h80;
  localparam logic [BYTE_W-1:0] DT_EOT_MORE   = 8'h00;

  // header step index in the back end; STEP_PAYLOAD sends the data word
  localparam logic [2:0] STEP_VERSION  = 3'd0;
  localparam logic [2:0] STEP_RESERVED = 3'd1;
  localparam logic [2:0] STEP_LEN_HI   = 3'd2;
  localparam logic [2:0] STEP_LEN_LO   = 3'd3;
  localparam logic [2:0] STEP_LI       = 3'd4;
  localparam logic [2:0] STEP_CODE     = 3'd5;
  localparam logic [2:0] STEP_EOT      = 3'd6;
  localparam logic [2:0] STEP_PAYLOAD  = 3'd7;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // one classified payload byte, queued between front and back end
  typedef struct packed {
    logic [BYTE_W-1:0]     data;
    logic                  need_hdr;
    logic [TPKT_LEN_W-1:0] tpkt_len;
    logic                  last_frag;
    logic                  eot;
    logic                  eom;
  } seg_entry_t;

endpackage

@@ design/cds_if.sv @@
// cds_if: valid/ready channel interfaces of the COTP data segmenter.
// Depends on cds_pkg.
interface cds_in_if import cds_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [BYTE_W-1:0]    payload_byte;
  logic [MSG_LEN_W-1:0] message_length;

  modport source (output valid, output payload_byte, output message_length, input ready);
  modport sink   (input valid, input payload_byte, input message_length, output ready);
endinterface

interface cds_out_if import cds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              end_of_tpdu;
  logic              end_of_message;
  logic              last_of_run;

  modport source (output valid, output out_byte, output end_of_tpdu,
                  output end_of_message, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input end_of_tpdu,
                  input end_of_message, input last_of_run, output ready);
endinterface

interface cds_cfg_if import cds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TPDU_W-1:0] tpdu_size;

  modport source (output valid, output tpdu_size, input ready);
  modport sink   (input valid, input tpdu_size, output ready);
endinterface

@@ design/cds_front.sv @@
// cds_front: accepts payload words, tracks message and fragment counts,
// classifies each word. Depends on cds_pkg and cds_if.
module cds_front import cds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cds_in_if.sink      in_i,
  cds_cfg_if.sink     cfg_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output seg_entry_t  q_entry_o
);

  logic [TPDU_W-1:0]    tpdu_q;
  logic [MSG_LEN_W-1:0] msg_left_q, msg_left_d;
  logic [FRAG_W-1:0]    frag_left_q, frag_left_d;
  logic [FRAG_W-1:0]    cap_q, cap_d;

  logic [MSG_LEN_W-1:0] len_sat, msg_cur;
  logic [TPDU_W-1:0]    size_clamp;
  logic [FRAG_W-1:0]    cap_new, cap_cur, frag_cur, frag_sel;
  logic                 starting, need_hdr, over_cap, accept;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !q_full_i;
  assign accept      = in_i.valid && !q_full_i;

  always_comb begin
    // sample-time length and capacity
    len_sat = in_i.message_length;
    if (len_sat == '0) len_sat = MSG_LEN_W'(1);
    if (len_sat > MAX_MESSAGE_BYTES) len_sat = MAX_MESSAGE_BYTES;
    size_clamp = tpdu_q;
    if (size_clamp < TPDU_MIN) size_clamp = TPDU_MIN;
    if (size_clamp > TPDU_MAX) size_clamp = TPDU_MAX;
    cap_new = FRAG_W'(size_clamp - DATA_HEADER_BYTES);

    starting = (msg_left_q == '0);
    msg_cur  = starting ? len_sat : msg_left_q;
    cap_cur  = starting ? cap_new : cap_q;
    frag_cur = starting ? '0 : frag_left_q;

    need_hdr = (frag_cur == '0);
    over_cap = (msg_cur > MSG_LEN_W'(cap_cur));
    frag_sel = need_hdr ? (over_cap ? cap_cur : msg_cur[FRAG_W-1:0]) : frag_cur;

    frag_left_d = frag_sel - FRAG_W'(1);
    msg_left_d  = msg_cur - MSG_LEN_W'(1);
    cap_d       = cap_cur;

    q_entry_o.data      = in_i.payload_byte;
    q_entry_o.need_hdr  = need_hdr;
    q_entry_o.tpkt_len  = TPKT_LEN_W'(frag_sel) + FRAME_HEADER_BYTES;
    q_entry_o.last_frag = !over_cap;
    q_entry_o.eot       = (frag_left_d == '0);
    q_entry_o.eom       = (msg_left_d == '0);
    q_push_o            = accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpdu_q      <= TPDU_RESET;
      msg_left_q  <= '0;
      frag_left_q <= '0;
      cap_q       <= '0;
    end else begin
      if (cfg_i.valid) tpdu_q <= cfg_i.tpdu_size;
      if (accept) begin
        msg_left_q  <= msg_left_d;
        frag_left_q <= frag_left_d;
        cap_q       <= cap_d;
      end
    end
  end

endmodule

@@ design/cds_fifo.sv @@
// cds_fifo: short queue of classified words between front and back end.
// Depends on cds_pkg.
module cds_fifo import cds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  seg_entry_t push_entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output seg_entry_t head_o
);

  seg_entry_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]       count_q;

  assign full_o  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (QUEUE_AW+1)'(1);
        2'b01:   count_q <= count_q - (QUEUE_AW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ design/cds_back.sv @@
// cds_back: expands queued words into header and payload output words,
// through a registered output stage. Depends on cds_pkg and cds_if.
module cds_back import cds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  seg_entry_t q_head_i,
  output logic       q_pop_o,
  cds_out_if.source  out_o
);

  logic [2:0]        step_q, step_d;
  logic              ovalid_q, ovalid_d;
  logic [BYTE_W-1:0] obyte_q, obyte_d;
  logic              oeot_q, oeot_d, oeom_q, oeom_d, olast_q, olast_d;
  logic              adv, send_payload;

  assign out_o.valid          = ovalid_q;
  assign out_o.out_byte       = obyte_q;
  assign out_o.end_of_tpdu    = oeot_q;
  assign out_o.end_of_message = oeom_q;
  assign out_o.last_of_run    = olast_q;

  always_comb begin
    adv          = !q_empty_i && (!ovalid_q || out_o.ready);
    send_payload = !q_head_i.need_hdr || (step_q == STEP_PAYLOAD);
    q_pop_o      = adv && send_payload;

    step_d = step_q;
    if (adv) step_d = send_payload ? STEP_VERSION : step_q + 3'd1;

    ovalid_d = adv ? 1'b1 : (out_o.ready ? 1'b0 : ovalid_q);

    oeot_d  = 1'b0;
    oeom_d  = 1'b0;
    olast_d = 1'b0;
    obyte_d = q_head_i.data;
    if (send_payload) begin
      oeot_d  = q_head_i.eot;
      oeom_d  = q_head_i.eom;
      olast_d = 1'b1;
    end else begin
      case (step_q)
        STEP_VERSION:  obyte_d = TPKT_VERSION;
        STEP_RESERVED: obyte_d = TPKT_RESERVED;
        STEP_LEN_HI:   obyte_d = BYTE_W'(q_head_i.tpkt_len[TPKT_LEN_W-1:BYTE_W]);
        STEP_LEN_LO:   obyte_d = q_head_i.tpkt_len[BYTE_W-1:0];
        STEP_LI:       obyte_d = DT_LI;
        STEP_CODE:     obyte_d = DT_CODE;
        STEP_EOT:      obyte_d = q_head_i.last_frag ? DT_EOT_LAST : DT_EOT_MORE;
        default:       obyte_d = q_head_i.data;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= STEP_VERSION;
      ovalid_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      obyte_q <= obyte_d;
      oeot_q  <= oeot_d;
      oeom_q  <= oeom_d;
      olast_q <= olast_d;
    end
  end

endmodule

@@ design/cotp_data_segmenter.sv @@
// cotp_data_segmenter: top level, splits a message into COTP DT TPDUs in TPKT frames.
// Depends on cds_pkg, cds_if, cds_front, cds_fifo, cds_back.
//
//  channel    dir  handshake         payload
//  seg_in_i   in   valid/ready       payload_byte[7:0], message_length[16:0]
//  cfg_i      in   valid/ready (=1)  tpdu_size[13:0]
//  seg_out_o  out  valid/ready       out_byte[7:0], end_of_tpdu, end_of_message, last_of_run
//
// Output: a payload word that opens a fragment is sent after 7 header words,
// any other word alone; the back end's single output register sends one
// word per cycle while the queue holds a word and the sink is ready.
// The front end takes a word every cycle while the 4-entry queue has room.
// An accepted word is written into the queue; the words built from it leave through the output register.
// rst_ni (async, active low) clears counters, queue and output valid;
// tpdu_size resets to 8192. Either side may stall freely.
module cotp_data_segmenter import cds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cds_in_if.sink     seg_in_i,
  cds_cfg_if.sink    cfg_i,
  cds_out_if.source  seg_out_o
);

  // front -> queue
  logic       push, full;
  seg_entry_t push_entry;
  // queue -> back
  logic       pop, empty;
  seg_entry_t head;

  // Front end: per-word classification (header needed, TPKT length,
  // last fragment, end of TPDU / message); capacity latched at message start.
  cds_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (seg_in_i),
    .cfg_i     (cfg_i),
    .q_full_i  (full),
    .q_push_o  (push),
    .q_entry_o (push_entry)
  );

  // Decoupling queue: front keeps accepting while the back end emits headers.
  cds_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .empty_o      (empty),
    .head_o       (head)
  );

  // Back end: header sequencer plus registered output stage.
  cds_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (empty),
    .q_head_i  (head),
    .q_pop_o   (pop),
    .out_o     (seg_out_o)
  );

endmodule

@@ test/cotp_data_segmenter_tb.sv @@
// Testbench of cotp_data_segmenter: drives message bytes and tpdu_size writes, predicts
// every TPKT/DT header and payload word in a scoreboard class and checks the output stream.
// Depends on cds_pkg, cds_if and the design files.
`timescale 1ns / 100ps

import cds_pkg::*;

// one output word as the sink sees it
typedef struct packed {
  logic [BYTE_W-1:0] out_byte;
  logic              end_of_tpdu;
  logic              end_of_message;
  logic              last_of_run;
} seg_word_t;

// Mirrors the segmenter: message/fragment counters, the latched fragment
// capacity and the register, plus the queue of words still to come.
class frame_scoreboard;
  logic [TPDU_W-1:0]    tpdu_size;
  logic [MSG_LEN_W-1:0] msg_left;
  logic [TPDU_W-1:0]    frag_left;
  logic [TPDU_W-1:0]    frag_cap;
  seg_word_t            expected_q[$];
  int unsigned          mismatches;

  function new();
    tpdu_size  = TPDU_RESET;
    msg_left   = '0;
    frag_left  = '0;
    frag_cap   = '0;
    mismatches = 0;
  endfunction

  function void note_tpdu(logic [TPDU_W-1:0] value);
    tpdu_size = value;
  endfunction

  function bit in_message();
    return msg_left != 0;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function void push_word(logic [BYTE_W-1:0] b, logic eot, logic eom, logic last);
    seg_word_t w;
    w.out_byte       = b;
    w.end_of_tpdu    = eot;
    w.end_of_message = eom;
    w.last_of_run    = last;
    expected_q.push_back(w);
  endfunction

  // one accepted payload word -> 1 or 8 expected output words
  function void note_input(logic [BYTE_W-1:0] data, logic [MSG_LEN_W-1:0] len);
    logic [MSG_LEN_W-1:0] n;
    logic [TPDU_W-1:0]    size;
    logic [MSG_LEN_W-1:0] frag;
    logic [15:0]          tpkt_len;
    logic                 last_frag;
    if (msg_left == 0) begin
      // length and capacity are sampled on the first word only
      n = (len == 0) ? 17'd1 : len;
      if (n > MAX_MESSAGE_BYTES) n = MAX_MESSAGE_BYTES;
      size = tpdu_size;
      if (size < TPDU_MIN) size = TPDU_MIN;
      if (size > TPDU_MAX) size = TPDU_MAX;
      msg_left  = n;
      frag_left = '0;
      frag_cap  = size - DATA_HEADER_BYTES;
    end
    if (frag_left == 0) begin
      last_frag = msg_left <= MSG_LEN_W'(frag_cap);
      frag      = last_frag ? msg_left : MSG_LEN_W'(frag_cap);
      tpkt_len  = {2'b00, FRAME_HEADER_BYTES} + frag[15:0];
      push_word(TPKT_VERSION, 1'b0, 1'b0, 1'b0);
      push_word(TPKT_RESERVED, 1'b0, 1'b0, 1'b0);
      push_word(tpkt_len[15:8], 1'b0, 1'b0, 1'b0);
      push_word(tpkt_len[7:0], 1'b0, 1'b0, 1'b0);
      push_word(DT_LI, 1'b0, 1'b0, 1'b0);
      push_word(DT_CODE, 1'b0, 1'b0, 1'b0);
      push_word(last_frag ? DT_EOT_LAST : DT_EOT_MORE, 1'b0, 1'b0, 1'b0);
      frag_left = frag[TPDU_W-1:0];
    end
    frag_left = frag_left - TPDU_W'(1);
    msg_left  = msg_left - MSG_LEN_W'(1);
    push_word(data, frag_left == 0, msg_left == 0, 1'b1);
  endfunction

  function void report(string field, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
  endfunction

  function void check_word(seg_word_t got);
    seg_word_t want;
    if (expected_q.size() == 0) begin
      report("unexpected word", 8'h00, got.out_byte);
      return;
    end
    want = expected_q.pop_front();
    if (got.out_byte !== want.out_byte)
      report("out_byte", want.out_byte, got.out_byte);
    if (got.end_of_tpdu !== want.end_of_tpdu)
      report("end_of_tpdu", {7'b0, want.end_of_tpdu}, {7'b0, got.end_of_tpdu});
    if (got.end_of_message !== want.end_of_message)
      report("end_of_message", {7'b0, want.end_of_message}, {7'b0, got.end_of_message});
    if (got.last_of_run !== want.last_of_run)
      report("last_of_run", {7'b0, want.last_of_run}, {7'b0, got.last_of_run});
  endfunction

  function bit clean();
    if (expected_q.size() != 0)
      $display("%0d words still expected", expected_q.size());
    return mismatches == 0 && expected_q.size() == 0;
  endfunction
endclass

module cotp_data_segmenter_tb;
  localparam int RANDOM_ITEMS = 260;
  localparam int QUIET_ITEMS  = 60;     // tail of the random part without idling
  localparam int HOLD_CYCLES  = 250;    // long sink hold-off, fills the block
  localparam int HOLD_PHASE   = 2;
  localparam int OPEN_BYTES   = 60;     // bytes sent of the final oversized message after its first byte
  localparam int SETTLE       = 6;      // idle margin after the last expected word is out
  localparam int LIMIT_CYCLES = 600000;

  logic clk_i;
  logic rst_ni;

  cds_in_if  seg_in ();
  cds_cfg_if cfg ();
  cds_out_if seg_out ();

  cotp_data_segmenter dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seg_in_i  (seg_in),
    .cfg_i     (cfg),
    .seg_out_o (seg_out)
  );

  frame_scoreboard sb;
  int unsigned tx_gap_odds;    // 0: sender never idles
  int unsigned rx_stall_odds;  // 0: sink never stalls
  logic        hold_req;
  int unsigned cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // offer one payload word, hold it until taken, then maybe idle a burst
  task automatic send_word(input logic [BYTE_W-1:0] data, input logic [MSG_LEN_W-1:0] len);
    seg_in.valid          <= 1'b1;
    seg_in.payload_byte   <= data;
    seg_in.message_length <= len;
    do @(posedge clk_i); while (!seg_in.ready);
    sb.note_input(data, len);
    if (tx_gap_odds != 0 && $urandom_range(0, tx_gap_odds - 1) == 0) begin
      seg_in.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // sender off, every expected word out, then SETTLE spare cycles
  task automatic wait_idle();
    seg_in.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_tpdu(input logic [TPDU_W-1:0] value);
    wait_idle();
    cfg.valid     <= 1'b1;
    cfg.tpdu_size <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    sb.note_tpdu(value);
  endtask

  // mostly small sizes so that fragments stay short; extremes and out of range too
  function automatic logic [TPDU_W-1:0] pick_tpdu();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return TPDU_MIN - TPDU_W'(1);
    if (r == 2) return '1;
    if (r == 3) return TPDU_W'($urandom_range(TPDU_MAX + 1, 16383));
    if (r < 8) return TPDU_MAX;
    if (r < 12) return TPDU_MIN;
    return TPDU_W'($urandom_range(TPDU_MIN, 400));
  endfunction

  // the length only counts on a message's first word; elsewhere it is noise
  function automatic logic [MSG_LEN_W-1:0] pick_length();
    int unsigned r;
    if (sb.in_message()) return MSG_LEN_W'($urandom_range(0, 17'h1FFFF));
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 25) return MSG_LEN_W'($urandom_range(1, 3));
    if (r < 85) return MSG_LEN_W'($urandom_range(4, 300));
    return MSG_LEN_W'($urandom_range(301, 600));
  endfunction

  function automatic int unsigned pick_odds();
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(2, 8);
  endfunction

  // sink: checks each taken word, stalls in bursts, one long hold-off on request
  initial begin : sink_side
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    seg_word_t   got;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    seg_out.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (seg_out.valid && seg_out.ready) begin
        got.out_byte       = seg_out.out_byte;
        got.end_of_tpdu    = seg_out.end_of_tpdu;
        got.end_of_message = seg_out.end_of_message;
        got.last_of_run    = seg_out.last_of_run;
        sb.check_word(got);
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        seg_out.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        seg_out.ready <= 1'b0;
      end else begin
        seg_out.ready <= 1'b1;
        if (rx_stall_odds != 0 && $urandom_range(0, rx_stall_odds - 1) == 0)
          stall_left = $urandom_range(1, 17);
      end
    end
  end

  initial begin : source_side
    int unsigned random_items;
    int unsigned phase;
    int unsigned n;
    bit          quiet;
    sb = new();
    tx_gap_odds   = 3;
    rx_stall_odds = 4;
    rst_ni                <= 1'b0;
    hold_req              <= 1'b0;
    seg_in.valid          <= 1'b0;
    seg_in.payload_byte   <= '0;
    seg_in.message_length <= '0;
    cfg.valid             <= 1'b0;
    cfg.tpdu_size         <= TPDU_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset tpdu_size; zero length is a one-word message
    send_word(8'h00, '0);
    send_word(8'hFF, 17'd1);
    // length on later words must be ignored
    send_word(8'hA5, 17'd3);
    send_word(8'h5A, 17'h1FFFF);
    send_word(8'h3C, '0);
    // out-of-range sizes clamp to 128 / 8192
    write_tpdu('0);
    send_word(8'h81, 17'd2);
    send_word(8'h7E, 17'd9);
    write_tpdu(TPDU_MIN - TPDU_W'(1));
    send_word(8'h01, 17'd1);
    write_tpdu('1);
    send_word(8'hFE, 17'd1);
    write_tpdu(TPDU_MAX + TPDU_W'(1));
    send_word(8'h55, 17'd2);
    send_word(8'hAA, 17'd2);
    // capacity of 125 latched here; the write after it must not change the split
    write_tpdu(TPDU_MIN);
    send_word(8'h0F, 17'd200);
    send_word(8'hF0, 17'd7);
    send_word(8'h33, 17'd1);
    write_tpdu(TPDU_MAX);

    // random phases; each phase boundary may fall inside a message
    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      quiet         = random_items >= RANDOM_ITEMS - QUIET_ITEMS;
      tx_gap_odds   = quiet ? 0 : pick_odds();
      rx_stall_odds = quiet ? 0 : pick_odds();
      write_tpdu(pick_tpdu());
      if (phase == HOLD_PHASE) begin
        // sink holds off while the sender keeps pushing: queue fills, input stalls
        hold_req   <= 1'b1;
        tx_gap_odds = 0;
        n           = 60;
      end else begin
        n = $urandom_range(20, 80);
      end
      repeat (n) send_word(BYTE_W'($urandom_range(0, 255)), pick_length());
      random_items += n;
      phase++;
    end

    // close the open message, then start one with every length bit set:
    // saturates to 64 KiB and stays open at the end of the run
    while (sb.in_message()) send_word(BYTE_W'($urandom_range(0, 255)), pick_length());
    write_tpdu(TPDU_MIN);
    send_word(BYTE_W'($urandom_range(0, 255)), 17'h1FFFF);
    repeat (OPEN_BYTES)
      send_word(BYTE_W'($urandom_range(0, 255)), MSG_LEN_W'($urandom_range(0, 17'h1FFFF)));

    wait_idle();
    if (sb.clean())
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
